// ===== rtl/core/mmpr_pkg.sv =====
// Shared types, widths and helpers for the mecanum mixer with per-wheel PI ramp.
// Used by mmpr_cfg, mmpr_ctrl, mmpr_dp and mecanum_mix_pi_ramp_unit; depends on nothing.
package mmpr_pkg;

  // Fraction bits of the ramp state (valid range 8 to 24)
  localparam int FRAC_BITS   = 16;

  localparam int WHEELS      = 4;
  localparam int WHEEL_IDX_W = 2;
  localparam int CMD_W       = 8;
  localparam int GEAR_W      = 2;
  localparam int DRIVE_W     = 16;
  localparam int STATE_W     = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 16;
  localparam int ARM_W       = 16;
  localparam int KGAIN_W     = 16;
  localparam int GAIN_Q      = 12;
  localparam int TARGET_Q    = 16;

  // Datapath widths
  localparam int TURN_W  = CMD_W + ARM_W + 1;
  localparam int MIX_W   = TURN_W + 1;
  localparam int TGT_W   = LIMIT_W + 1;
  localparam int CLAMP_W = LIMIT_W + TARGET_Q + 2;
  localparam int ERR_W   = ((TGT_W + FRAC_BITS) > STATE_W ? TGT_W + FRAC_BITS : STATE_W) + 1;
  localparam int MUL_A_W = (ERR_W > MIX_W) ? ERR_W : MIX_W;
  localparam int MUL_B_W = KGAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RND_W   = PROD_W - GAIN_Q;
  localparam int SUM_W   = RND_W + 1;

  // Saturation bounds of the 32-bit ramp state, at sum width
  localparam logic signed [SUM_W-1:0] STATE_MAX =
    {{(SUM_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] STATE_MIN =
    {{(SUM_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};

  // Wheel order, also the packing order of the result beat
  localparam logic [WHEEL_IDX_W-1:0] WHEEL_LF = 2'd0;
  localparam logic [WHEEL_IDX_W-1:0] WHEEL_LB = 2'd1;
  localparam logic [WHEEL_IDX_W-1:0] WHEEL_RF = 2'd2;
  localparam logic [WHEEL_IDX_W-1:0] WHEEL_RB = 2'd3;

  // Gear codes
  localparam logic [GEAR_W-1:0] GEAR_STOP = 2'd0;
  localparam logic [GEAR_W-1:0] GEAR_ONE  = 2'd1;
  localparam logic [GEAR_W-1:0] GEAR_TWO  = 2'd2;
  localparam logic [GEAR_W-1:0] GEAR_THREE = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GEAR1    = 3'd0,
    REG_GEAR2    = 3'd1,
    REG_GEAR3    = 3'd2,
    REG_ARM      = 3'd3,
    REG_PROP     = 3'd4,
    REG_INTEG    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] gear1;
    logic [CFG_DATA_W-1:0] gear2;
    logic [CFG_DATA_W-1:0] gear3;
    logic [ARM_W-1:0]      arm;
    logic [KGAIN_W-1:0]    kp;
    logic [KGAIN_W-1:0]    ki;
  } cfg_t;

  // Operand pair of the shared multiplier
  typedef enum logic [1:0] {
    MUL_TURN = 2'd0,
    MUL_MIX  = 2'd1,
    MUL_KP   = 2'd2,
    MUL_KI   = 2'd3
  } mul_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RUN    = 2'd1,
    ST_FINISH = 2'd2
  } ctrl_state_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic                   capture;
    mul_sel_t               mul_sel;
    logic                   turn_en;
    logic [WHEEL_IDX_W-1:0] mix_idx;
    logic                   tgt_en;
    logic [WHEEL_IDX_W-1:0] tgt_idx;
    logic                   err_en;
    logic [WHEEL_IDX_W-1:0] err_idx;
    logic                   prop_en;
    logic                   ri_en;
    logic                   int_en;
    logic [WHEEL_IDX_W-1:0] int_idx;
    logic                   sum_en;
    logic [WHEEL_IDX_W-1:0] sum_idx;
    logic                   res_en;
    logic [WHEEL_IDX_W-1:0] res_idx;
    logic                   load_out;
  } dp_cmd_t;

  // Clip a widened sum back to the 32-bit ramp state
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    if (v > STATE_MAX) begin
      c = STATE_MAX;
    end else if (v < STATE_MIN) begin
      c = STATE_MIN;
    end else begin
      c = v;
    end
    return c[STATE_W-1:0];
  endfunction

endpackage

// ===== rtl/core/mmpr_cfg.sv =====
// Configuration register file: gear words, rotation arm and ramp gains.
// Depends on mmpr_pkg.
module mmpr_cfg
  import mmpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; drop unknown indexes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_GEAR1: cfg_nxt.gear1 = cfg_wdata;
        REG_GEAR2: cfg_nxt.gear2 = cfg_wdata;
        REG_GEAR3: cfg_nxt.gear3 = cfg_wdata;
        REG_ARM:   cfg_nxt.arm   = cfg_wdata[ARM_W-1:0];
        REG_PROP:  cfg_nxt.kp    = cfg_wdata[KGAIN_W-1:0];
        REG_INTEG: cfg_nxt.ki    = cfg_wdata[KGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gear1 <= '0;
      cfg_r.gear2 <= '0;
      cfg_r.gear3 <= '0;
      cfg_r.arm   <= ARM_W'(256);
      cfg_r.kp    <= KGAIN_W'(4096);
      cfg_r.ki    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/mmpr_ctrl.sv =====
// Sequencer: accepts a beat, steps the datapath through mix, target and ramp
// stages, and hands the result to the output register. Depends on mmpr_pkg.
module mmpr_ctrl
  import mmpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  localparam int STEP_W = 5;
  // Wheel w enters the ramp pipeline at WHEEL_BASE + 2*w
  localparam logic [STEP_W-1:0] WHEEL_BASE = STEP_W'(4);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(16);
  localparam logic [STEP_W-1:0] STAGE_SPAN = STEP_W'(6);
  localparam logic [STEP_W-1:0] MIX_FIRST  = STEP_W'(1);
  localparam logic [STEP_W-1:0] MIX_LAST   = STEP_W'(4);
  localparam logic [STEP_W-1:0] TGT_FIRST  = STEP_W'(2);
  localparam logic [STEP_W-1:0] TGT_LAST   = STEP_W'(5);

  ctrl_state_t         state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                run;
  logic [STEP_W-1:0]   mix_ofs, tgt_ofs;

  // {hit, wheel} of a ramp stage that sits ofs steps after WHEEL_BASE
  function automatic logic [WHEEL_IDX_W:0] stage_dec(input logic [STEP_W-1:0] step,
                                                     input logic [STEP_W-1:0] ofs);
    logic [STEP_W-1:0] start;
    logic [STEP_W-1:0] d;
    start = WHEEL_BASE + ofs;
    d     = step - start;
    return {(step >= start) && (d <= STAGE_SPAN) && !d[0], d[WHEEL_IDX_W:1]};
  endfunction

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_RUN;
      ST_RUN:    if (step_r == LAST_STEP) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Step counter and output valid
  always_comb begin
    step_nxt = (state_r == ST_RUN) ? step_r + STEP_W'(1) : '0;
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Datapath commands
  always_comb begin
    logic [WHEEL_IDX_W:0] s_err, s_kp, s_ki, s_ri, s_int, s_sum, s_res;
    cmd       = '0;
    in_tready = 1'b0;
    run       = 1'b0;
    mix_ofs   = step_r - MIX_FIRST;
    tgt_ofs   = step_r - TGT_FIRST;
    s_err = stage_dec(step_r, STEP_W'(0));
    s_kp  = stage_dec(step_r, STEP_W'(1));
    s_ki  = stage_dec(step_r, STEP_W'(2));
    s_ri  = stage_dec(step_r, STEP_W'(3));
    s_int = stage_dec(step_r, STEP_W'(4));
    s_sum = stage_dec(step_r, STEP_W'(5));
    s_res = stage_dec(step_r, STEP_W'(6));
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_RUN: begin
        run = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_out = !out_valid_r || out_tready;
      end
      default: ;
    endcase
    if (run) begin
      // Multiplier: turn term, then wheel mixes, then ramp gains
      if (step_r == '0) begin
        cmd.mul_sel = MUL_TURN;
        cmd.turn_en = 1'b1;
      end else if (step_r >= MIX_FIRST && step_r <= MIX_LAST) begin
        cmd.mul_sel = MUL_MIX;
      end else if (s_kp[WHEEL_IDX_W]) begin
        cmd.mul_sel = MUL_KP;
      end else begin
        cmd.mul_sel = MUL_KI;
      end
      cmd.mix_idx = mix_ofs[WHEEL_IDX_W-1:0];
      cmd.tgt_en  = (step_r >= TGT_FIRST) && (step_r <= TGT_LAST);
      cmd.tgt_idx = tgt_ofs[WHEEL_IDX_W-1:0];
      cmd.err_en  = s_err[WHEEL_IDX_W];
      cmd.err_idx = s_err[WHEEL_IDX_W-1:0];
      cmd.prop_en = s_ki[WHEEL_IDX_W];
      cmd.ri_en   = s_ri[WHEEL_IDX_W];
      cmd.int_en  = s_int[WHEEL_IDX_W];
      cmd.int_idx = s_int[WHEEL_IDX_W-1:0];
      cmd.sum_en  = s_sum[WHEEL_IDX_W];
      cmd.sum_idx = s_sum[WHEEL_IDX_W-1:0];
      cmd.res_en  = s_res[WHEEL_IDX_W];
      cmd.res_idx = s_res[WHEEL_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/core/mmpr_dp.sv =====
// Datapath: shared multiplier, wheel mix and clamp, per-wheel PI ramp state
// and the output register. Steered by mmpr_ctrl; depends on mmpr_pkg.
module mmpr_dp
  import mmpr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  input  cfg_t                       cfg,
  input  logic signed [CMD_W-1:0]    forward_cmd,
  input  logic signed [CMD_W-1:0]    sideways_cmd,
  input  logic signed [CMD_W-1:0]    turn_cmd,
  input  logic [GEAR_W-1:0]          gear_select,
  output logic [WHEELS*DRIVE_W-1:0]  drive_bus
);

  localparam int OR_W = STATE_W + 1;
  localparam int FS_W = CMD_W + 1;
  localparam logic signed [CLAMP_W-1:0] T_HALF    = CLAMP_W'(1) <<< (TARGET_Q - 1);
  localparam logic signed [CLAMP_W-1:0] T_HALF_M1 = T_HALF - CLAMP_W'(1);
  localparam logic signed [PROD_W-1:0]  G_HALF    = PROD_W'(1) <<< (GAIN_Q - 1);
  localparam logic signed [PROD_W-1:0]  G_HALF_M1 = G_HALF - PROD_W'(1);
  localparam logic signed [OR_W-1:0]    F_HALF    = OR_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [OR_W-1:0]    F_HALF_M1 = F_HALF - OR_W'(1);
  localparam logic signed [OR_W-1:0]    DRIVE_MAX = OR_W'(32767);
  localparam logic signed [OR_W-1:0]    DRIVE_MIN = -OR_W'(32768);

  // Captured beat and selected gear
  logic signed [CMD_W-1:0]   fwd_r, side_r, tcmd_r;
  logic [GAIN_W-1:0]         gain_r;
  logic [LIMIT_W-1:0]        limit_r;
  logic [CFG_DATA_W-1:0]     gear_word;

  // Pipeline registers
  logic signed [TURN_W-1:0]  turn_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [TGT_W-1:0]   tgt_r [WHEELS];
  logic signed [ERR_W-1:0]   err_r;
  logic signed [RND_W-1:0]   prop_r, prop2_r, prop3_r, ri_r;
  logic signed [STATE_W-1:0] isum_r, osum_r;
  logic signed [DRIVE_W-1:0] res_r [WHEELS];
  logic signed [DRIVE_W-1:0] drive_r [WHEELS];

  // Ramp state
  logic signed [STATE_W-1:0] prev_r [WHEELS];
  logic signed [STATE_W-1:0] integ_r [WHEELS];

  // Combinational values
  logic signed [FS_W-1:0]    fs_sum, fs_diff, fs_base;
  logic signed [MIX_W-1:0]   base_sh, turn_ext, mix;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PROD_W-1:0]  lim_pos, lim_neg;
  logic signed [CLAMP_W-1:0] clamped, tgt_add;
  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [PROD_W-1:0]  prod_add;
  logic signed [RND_W-1:0]   prod_rnd;
  logic signed [SUM_W-1:0]   int_sum, out_sum;
  logic signed [STATE_W-1:0] isum_nxt, osum_nxt;
  logic signed [OR_W-1:0]    o_add, o_shr;
  logic signed [DRIVE_W-1:0] res_nxt;

  // Pick the gear word
  always_comb begin
    case (gear_select)
      GEAR_ONE:   gear_word = cfg.gear1;
      GEAR_TWO:   gear_word = cfg.gear2;
      GEAR_THREE: gear_word = cfg.gear3;
      default:    gear_word = '0;
    endcase
  end

  // Wheel mix: (f +- s) * 256 +- arm * t
  always_comb begin
    fs_sum  = {fwd_r[CMD_W-1], fwd_r} + {side_r[CMD_W-1], side_r};
    fs_diff = {fwd_r[CMD_W-1], fwd_r} - {side_r[CMD_W-1], side_r};
    fs_base = (cmd.mix_idx == WHEEL_LB || cmd.mix_idx == WHEEL_RF) ? fs_sum : fs_diff;
    base_sh  = MIX_W'(fs_base) <<< 8;
    turn_ext = MIX_W'(turn_r);
    mix = (cmd.mix_idx == WHEEL_RF || cmd.mix_idx == WHEEL_RB) ? base_sh + turn_ext
                                                                : base_sh - turn_ext;
  end

  // Shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_TURN: begin
        mul_a = MUL_A_W'(tcmd_r);
        mul_b = {1'b0, cfg.arm};
      end
      MUL_MIX: begin
        mul_a = MUL_A_W'(mix);
        mul_b = {1'b0, gain_r};
      end
      MUL_KP: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = {1'b0, cfg.kp};
      end
      default: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = {1'b0, cfg.ki};
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Clamp to +-limit and round the target half away from zero
  always_comb begin
    lim_pos = $signed({{(PROD_W-LIMIT_W-TARGET_Q){1'b0}}, limit_r, {TARGET_Q{1'b0}}});
    lim_neg = -lim_pos;
    if (prod_r > lim_pos) begin
      clamped = lim_pos[CLAMP_W-1:0];
    end else if (prod_r < lim_neg) begin
      clamped = lim_neg[CLAMP_W-1:0];
    end else begin
      clamped = prod_r[CLAMP_W-1:0];
    end
    tgt_add = clamped + (clamped[CLAMP_W-1] ? T_HALF_M1 : T_HALF);
  end

  // Ramp arithmetic
  always_comb begin
    err_nxt  = (ERR_W'(tgt_r[cmd.err_idx]) <<< FRAC_BITS) - ERR_W'(prev_r[cmd.err_idx]);
    prod_add = prod_r + (prod_r[PROD_W-1] ? G_HALF_M1 : G_HALF);
    prod_rnd = prod_add[PROD_W-1:GAIN_Q];
    int_sum  = SUM_W'(integ_r[cmd.int_idx]) + SUM_W'(ri_r);
    isum_nxt = sat_state(int_sum);
    out_sum  = SUM_W'(prop3_r) + SUM_W'(isum_r);
    osum_nxt = sat_state(out_sum);
    o_add    = OR_W'(osum_r) + (osum_r[STATE_W-1] ? F_HALF_M1 : F_HALF);
    o_shr    = o_add >>> FRAC_BITS;
    if (o_shr > DRIVE_MAX) begin
      res_nxt = DRIVE_MAX[DRIVE_W-1:0];
    end else if (o_shr < DRIVE_MIN) begin
      res_nxt = DRIVE_MIN[DRIVE_W-1:0];
    end else begin
      res_nxt = o_shr[DRIVE_W-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (cmd.capture) begin
      fwd_r   <= forward_cmd;
      side_r  <= sideways_cmd;
      tcmd_r  <= turn_cmd;
      gain_r  <= gear_word[GAIN_W-1:0];
      limit_r <= gear_word[CFG_DATA_W-1:GAIN_W];
    end
    if (cmd.turn_en) turn_r <= mul_p[TURN_W-1:0];
    if (cmd.tgt_en) tgt_r[cmd.tgt_idx] <= tgt_add[TARGET_Q +: TGT_W];
    if (cmd.err_en) err_r <= err_nxt;
    if (cmd.prop_en) prop_r <= prod_rnd;
    if (cmd.ri_en) begin
      ri_r    <= prod_rnd;
      prop2_r <= prop_r;
    end
    if (cmd.int_en) begin
      isum_r  <= isum_nxt;
      prop3_r <= prop2_r;
    end
    if (cmd.sum_en) osum_r <= osum_nxt;
    if (cmd.res_en) res_r[cmd.res_idx] <= res_nxt;
    if (cmd.load_out) begin
      for (int i = 0; i < WHEELS; i++) begin
        drive_r[i] <= res_r[i];
      end
    end
  end

  // Ramp state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WHEELS; i++) begin
        prev_r[i]  <= '0;
        integ_r[i] <= '0;
      end
    end else begin
      if (cmd.int_en) integ_r[cmd.int_idx] <= isum_nxt;
      if (cmd.sum_en) prev_r[cmd.sum_idx] <= osum_nxt;
    end
  end

  // Pack the drives, left front lowest
  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      drive_bus[i*DRIVE_W +: DRIVE_W] = drive_r[i];
    end
  end

endmodule

// ===== rtl/core/mecanum_mix_pi_ramp_unit.sv =====
// Mecanum wheel mixer with a PI ramp per wheel.
// Input beat: forward, sideways and turn stick commands plus a gear select.
// Output beat: four ramped, saturated wheel drives (LF, LB, RF, RB).
// Config: write port cfg_we/cfg_addr/cfg_wdata, six registers, no read-back;
// write only while no beat is in flight.
// Timing: a beat is taken in the idle cycle, then a 17-step sequence runs on
// one shared multiplier (turn term, four mix products, then kp and ki products
// per wheel) with the wheel ramps overlapped; the finish step then moves the
// drives into the output register. A new beat is taken only once the sequencer
// has returned to idle after the finish step.
// The output register decouples the two sides: the next beat is accepted and
// worked on while a finished result waits; if it is still not taken when the
// next one finishes, the sequencer holds in its finish step.
// Reset (rst_n low at a clock edge) clears the ramp state, the gear words and
// the integral gain, sets rotation arm to 1.0 and kp to 1.0, and empties the
// output register.
module mecanum_mix_pi_ramp_unit
  import mmpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [7:0] forward_cmd, [15:8] sideways_cmd, [23:16] turn_cmd,
  //           [25:24] gear_select, [31:26] zero
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,
  // out_tdata: [15:0] left_front_drive, [31:16] left_back_drive,
  //            [47:32] right_front_drive, [63:48] right_back_drive
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  mmpr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mmpr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mmpr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg          (cfg),
    .forward_cmd  ($signed(in_tdata[7:0])),
    .sideways_cmd ($signed(in_tdata[15:8])),
    .turn_cmd     ($signed(in_tdata[23:16])),
    .gear_select  (in_tdata[25:24]),
    .drive_bus    (out_tdata)
  );

endmodule
